// ===== hw/rtl/vectored_irq_dispatch_assert.svh =====
// Assertion macros for the vectored interrupt dispatcher.
`ifndef VECTORED_IRQ_DISPATCH_ASSERT_SVH
`define VECTORED_IRQ_DISPATCH_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define VID_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vid assertion failed");

// Check that cons holds in the cycle after ante.
`define VID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vid assertion failed");

`endif

// ===== hw/rtl/vid_pkg.sv =====
`timescale 1ns / 1ps

package vid_pkg;

   // Default configuration.
   localparam int NUM_SOURCES_DEF = 72;
   localparam int ADDR_WIDTH_DEF  = 32;

   // Fixed field widths.
   localparam int DATA_W      = 32;
   localparam int SRC_W       = 8;
   localparam int WIN_W       = 7;
   localparam int BANK_W      = 32;
   localparam int BASIC_W     = 8;
   localparam int RAW_LINES   = 2 * BANK_W + BASIC_W;

   // Action codes.
   localparam logic ACT_DISPATCH   = 1'b0;
   localparam logic ACT_SET_VECTOR = 1'b1;

   typedef struct packed {
      logic              action;
      logic [BANK_W-1:0] raw_lines_low;
      logic [BANK_W-1:0] raw_lines_high;
      logic [BASIC_W-1:0] raw_lines_basic;
      logic [DATA_W-1:0] return_address;
      logic [SRC_W-1:0]  source_select;
      logic [DATA_W-1:0] handler_address;
      logic [DATA_W-1:0] handler_argument;
   } req_payload_type;

   typedef struct packed {
      logic              dispatch_valid;
      logic [WIN_W-1:0]  winning_source;
      logic              handler_present;
      logic [DATA_W-1:0] call_target;
      logic [DATA_W-1:0] call_argument;
      logic              write_accepted;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENCODE,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/vid_if.sv =====
`timescale 1ns / 1ps

// Request channel: dispatch or set-vector items.
interface vid_req_if;
   logic                     valid;
   logic                     ready;
   vid_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// Response channel: one result per request.
interface vid_rsp_if;
   logic                     valid;
   logic                     ready;
   vid_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/vid_prio_enc.sv =====
`timescale 1ns / 1ps

// Lowest-set-bit priority encoder.
module vid_prio_enc #(
   parameter int WIDTH = vid_pkg::NUM_SOURCES_DEF,
   parameter int IDX_W = $clog2(WIDTH)
) (
   input  logic [WIDTH-1:0] pending,
   output logic             found,
   output logic [IDX_W-1:0] index
);

   logic [WIDTH-1:0] lowest;

   // Isolate the lowest set bit.
   assign lowest = pending & (~pending + WIDTH'(1));
   assign found  = |pending;

   // Encode the one-hot bit: each index bit ORs the positions that carry it.
   always_comb begin
      index = '0;
      for (int k = 0; k < IDX_W; k++) begin
         for (int i = 0; i < WIDTH; i++) begin
            if (((i >> k) & 1) == 1) begin
               index[k] = index[k] | lowest[i];
            end
         end
      end
   end

endmodule

// ===== hw/rtl/vectored_irq_dispatch.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Transfer when           Payload
// req_ch   in   valid && ready          action, raw lines, return address, vector
// rsp_ch   out  valid && ready          dispatch result or write acknowledge
//
// A set-vector item goes from the accept (idle) state straight to the finish
// state. A dispatch is accepted, then encodes the winner and reads its vector
// memory entry into a register in the encode state, and forms the result in finish.
// Reset clears the enable flops at once; the vector memory needs no pass.
// A result waits in the output register; a new item is taken meanwhile, and
// its result holds in the finish state until the output register frees.

`include "vectored_irq_dispatch_assert.svh"

module vectored_irq_dispatch #(
   parameter int NUM_SOURCES = vid_pkg::NUM_SOURCES_DEF,
   parameter int ADDR_WIDTH  = vid_pkg::ADDR_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   vid_req_if.sink   req_ch,
   vid_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(NUM_SOURCES);

   vid_pkg::state_type       state_ff, state_in;
   logic                     req_fire;
   logic                     out_free;

   logic [NUM_SOURCES-1:0]   enable_ff;
   logic [NUM_SOURCES-1:0]   pend_in;
   logic [NUM_SOURCES-1:0]   pend_ff;
   logic [vid_pkg::RAW_LINES-1:0] raw_all;

   logic                     action_ff;
   logic                     write_ok_ff;
   logic [ADDR_WIDTH-1:0]    ret_ff;

   logic                     src_in_range;
   logic [IDX_W-1:0]         wr_idx;
   logic [ADDR_WIDTH-1:0]    wr_fn;
   logic [ADDR_WIDTH-1:0]    wr_arg;

   logic [2*ADDR_WIDTH-1:0]  vec_mem [NUM_SOURCES];
   logic [2*ADDR_WIDTH-1:0]  rd_ff;

   logic                     enc_found;
   logic [IDX_W-1:0]         enc_idx;
   logic                     found_ff;
   logic [IDX_W-1:0]         win_ff;

   logic                     mem_wr_en;
   logic                     mem_rd_en;
   logic                     load_out;

   logic [ADDR_WIDTH-1:0]    rd_fn;
   logic [ADDR_WIDTH-1:0]    rd_arg;
   logic [ADDR_WIDTH-1:0]    call_arg;
   vid_pkg::rsp_payload_type result;

   logic                     rsp_valid_ff;
   vid_pkg::rsp_payload_type rsp_data_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Decode the set-vector write.
   assign src_in_range = req_ch.data.source_select < vid_pkg::SRC_W'(NUM_SOURCES);
   assign wr_idx       = req_ch.data.source_select[IDX_W-1:0];
   assign wr_fn        = ADDR_WIDTH'(req_ch.data.handler_address);
   assign wr_arg       = ADDR_WIDTH'(req_ch.data.handler_argument);

   // Form pending lines; sources beyond the raw lines are never pending.
   assign raw_all = {req_ch.data.raw_lines_basic, req_ch.data.raw_lines_high,
                     req_ch.data.raw_lines_low};
   for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_pend
      if (i < vid_pkg::RAW_LINES) begin : g_line
         assign pend_in[i] = raw_all[i] & enable_ff[i];
      end else begin : g_none
         assign pend_in[i] = 1'b0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vid_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.data.action == vid_pkg::ACT_SET_VECTOR) begin
                  state_in = vid_pkg::ST_FINISH;
               end else begin
                  state_in = vid_pkg::ST_ENCODE;
               end
            end
         end
         vid_pkg::ST_ENCODE: state_in = vid_pkg::ST_FINISH;
         vid_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = vid_pkg::ST_IDLE;
            end
         end
         default: state_in = vid_pkg::ST_IDLE;
      endcase
   end

   // Control outputs per state.
   always_comb begin
      req_ch.ready = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         vid_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            mem_wr_en    = req_ch.valid && src_in_range &&
                           (req_ch.data.action == vid_pkg::ACT_SET_VECTOR);
         end
         vid_pkg::ST_ENCODE: mem_rd_en = 1'b1;
         vid_pkg::ST_FINISH: load_out  = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vid_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Update enable bits on a set-vector transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
      end else if (mem_wr_en) begin
         enable_ff[wr_idx] <= (wr_fn != '0);
      end
   end

   // Capture the item.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff   <= req_ch.data.action;
         write_ok_ff <= src_in_range;
         pend_ff     <= pend_in;
         ret_ff      <= ADDR_WIDTH'(req_ch.data.return_address);
      end
   end

   // Vector memory: handler and argument per source.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         vec_mem[wr_idx] <= {wr_arg, wr_fn};
      end
   end

   vid_prio_enc #(
      .WIDTH (NUM_SOURCES),
      .IDX_W (IDX_W)
   ) u_prio_enc (
      .pending (pend_ff),
      .found   (enc_found),
      .index   (enc_idx)
   );

   // Read the winner's vector entry.
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_ff    <= vec_mem[enc_idx];
         found_ff <= enc_found;
         win_ff   <= enc_idx;
      end
   end

   // Form the result.
   assign rd_fn    = rd_ff[ADDR_WIDTH-1:0];
   assign rd_arg   = rd_ff[2*ADDR_WIDTH-1:ADDR_WIDTH];
   assign call_arg = (rd_arg != '0) ? rd_arg : ret_ff;

   always_comb begin
      result = '0;
      if (action_ff == vid_pkg::ACT_SET_VECTOR) begin
         result.write_accepted = write_ok_ff;
      end else if (found_ff) begin
         result.dispatch_valid = 1'b1;
         result.winning_source = vid_pkg::WIN_W'(win_ff);
         if (rd_fn != '0) begin
            result.handler_present = 1'b1;
            result.call_target     = vid_pkg::DATA_W'(rd_fn);
            result.call_argument   = vid_pkg::DATA_W'(call_arg);
         end
      end
   end

   // Hold the result until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Assertions.
   `VID_ASSERT_NEXT(a_dispatch_encodes, clock, reset,
      req_fire && (req_ch.data.action == vid_pkg::ACT_DISPATCH),
      state_ff == vid_pkg::ST_ENCODE)
   `VID_ASSERT_SAME(a_winner_enabled, clock, reset,
      (state_ff == vid_pkg::ST_FINISH) && (action_ff == vid_pkg::ACT_DISPATCH) && found_ff,
      enable_ff[win_ff])
   `VID_ASSERT_SAME(a_result_kind, clock, reset,
      rsp_valid_ff,
      !(rsp_data_ff.dispatch_valid && rsp_data_ff.write_accepted))

endmodule
